FILE: rtl/core/shsv_pkg.sv
package shsv_pkg;

	// Field widths and channel range.
	localparam int unsigned CHANNEL_BITS = 8;
	localparam int unsigned HUE_W = 12;
	localparam int unsigned CHAN_MAX = (1 << CHANNEL_BITS) - 1;
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 24;

	// Hue geometry: six segments of equal length make one turn.
	localparam int unsigned HUE_UNITS_PER_SEGMENT = 480;
	localparam int unsigned SEGS = 6;
	localparam int unsigned HUE_TURN = SEGS * HUE_UNITS_PER_SEGMENT;
	localparam int unsigned T_W = $clog2(HUE_UNITS_PER_SEGMENT);

	// Segment codes.
	typedef logic [2:0] seg_t;
	localparam seg_t SEG_TOP_A = 3'd0;
	localparam seg_t SEG_FALL = 3'd1;
	localparam seg_t SEG_OFF_A = 3'd2;
	localparam seg_t SEG_OFF_B = 3'd3;
	localparam seg_t SEG_RISE = 3'd4;
	localparam seg_t SEG_TOP_B = 3'd5;

	// Segment offsets of the green and blue channels.
	localparam int unsigned CH_OFF_GREEN = 2;
	localparam int unsigned CH_OFF_BLUE = 4;

	// Phase within a segment, Q16, found by a reciprocal multiply.
	localparam int unsigned PH_W = 16;
	localparam int unsigned PH_FRAC = 16;
	localparam int unsigned PH_RSHIFT = 32;
	localparam int unsigned PH_RECIP = 32'((64'd1 << PH_RSHIFT) / HUE_UNITS_PER_SEGMENT);
	localparam int unsigned PH_RECIP_W = $clog2(PH_RECIP + 1);
	localparam int unsigned PPR_W = T_W + PH_RECIP_W;
	localparam int unsigned X_W = T_W + PH_FRAC;
	localparam int unsigned ONE_Q16 = 65536;
	localparam int unsigned W_W = PH_W + 1;

	// Cosine polynomial in Q30.
	localparam int unsigned Q_FRAC = 30;
	localparam int unsigned ONE_Q30 = 1 << Q_FRAC;
	localparam int unsigned ACC_W = 31;
	localparam int unsigned Z_W = 2 * PH_W - 1;
	localparam int unsigned MUL_W = ACC_W + Z_W;
	localparam int unsigned SH_W = MUL_W - Q_FRAC;
	localparam int unsigned HORNER_N = 5;
	localparam int unsigned COS_SEED = 27061;
	localparam int unsigned ROUND_Q15 = 16384;

	// Pipeline stage numbers shared by the top level and its parts.
	localparam int unsigned STG_RAMP_FIRST = 3;
	localparam int unsigned STG_Z = 6;
	localparam int unsigned STG_COS = STG_Z + 2 * HORNER_N;
	localparam int unsigned STG_RAMP_LAST = STG_COS + 1;
	localparam int unsigned STG_CHAN_FIRST = STG_RAMP_LAST + 1;
	localparam int unsigned STG_LAST = STG_CHAN_FIRST + 7;

	// Constant that each Horner step subtracts from, highest order first.
	function automatic logic [ACC_W-1:0] horner_coef(input logic [2:0] idx);
		logic [ACC_W-1:0] c;
		case (idx)
			3'd0: c = ACC_W'(987048);
			3'd1: c = ACC_W'(22401990);
			3'd2: c = ACC_W'(272375560);
			3'd3: c = ACC_W'(1324675879);
			default: c = ACC_W'(ONE_Q30);
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/smooth_hsv_to_rgb_unit.sv
// Smooth HSV to RGB converter: raised-cosine ramps between the primaries.
// Pipeline: 25 register stages; a result is offered once its input has passed
// through all of them, and is held back only while the output side stalls.
// Throughput: one item per cycle; stalls are absorbed stage by stage.
// Reset clears the stage valid bits only; the data registers are not reset.
module smooth_hsv_to_rgb_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [shsv_pkg::S_TDATA_W-1:0] s_tdata, // hue[11:0], saturation[19:12], brightness[27:20], zero[31:28]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [shsv_pkg::M_TDATA_W-1:0] m_tdata  // red[7:0], green[15:8], blue[23:16]
);

	localparam int unsigned CB = shsv_pkg::CHANNEL_BITS;
	localparam int unsigned HUE_W = shsv_pkg::HUE_W;
	localparam int unsigned T_W = shsv_pkg::T_W;
	localparam int unsigned NSTG = shsv_pkg::STG_LAST;
	localparam int unsigned SC = shsv_pkg::STG_RAMP_LAST;

	logic [NSTG:1]     vld_q;
	logic [NSTG:1]     en;
	logic [HUE_W-1:0]  hm_s1;
	logic [T_W-1:0]    t_s2;
	logic [CB-1:0]     sat_s [1:SC];
	logic [CB-1:0]     bri_s [1:SC];
	shsv_pkg::seg_t    seg_s [2:SC];

	logic [HUE_W-1:0]  hue_c;
	logic [HUE_W-1:0]  hm_c;
	shsv_pkg::seg_t    seg_c;
	logic [T_W-1:0]    t_c;
	shsv_pkg::seg_t    seg_g_c;
	shsv_pkg::seg_t    seg_b_c;
	logic [shsv_pkg::W_W-1:0] fall;
	logic [CB-1:0]     red;
	logic [CB-1:0]     green;
	logic [CB-1:0]     blue;

	// Segment of a channel that sits a number of segments further along.
	function automatic shsv_pkg::seg_t seg_rotate(input shsv_pkg::seg_t s, input logic [2:0] off);
		logic [3:0] sum;
		sum = {1'b0, s} + {1'b0, off};
		if (sum >= 4'(shsv_pkg::SEGS)) begin
			sum = sum - 4'(shsv_pkg::SEGS);
		end
		return sum[2:0];
	endfunction

	// A stage loads when it is empty or when the stage after it loads.
	always_comb begin
		en[NSTG] = !vld_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NSTG];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Hue wrapped into one turn.
	always_comb begin
		hue_c = s_tdata[HUE_W-1:0];
		hm_c = (hue_c >= HUE_W'(shsv_pkg::HUE_TURN)) ? hue_c - HUE_W'(shsv_pkg::HUE_TURN) : hue_c;
	end

	// Segment number and offset inside the segment.
	always_comb begin
		seg_c = shsv_pkg::SEG_TOP_A;
		for (int k = 1; k < shsv_pkg::SEGS; k++) begin
			if (hm_s1 >= HUE_W'(k * shsv_pkg::HUE_UNITS_PER_SEGMENT)) begin
				seg_c = shsv_pkg::seg_t'(k);
			end
		end
		t_c = T_W'(hm_s1 - HUE_W'(seg_c) * HUE_W'(shsv_pkg::HUE_UNITS_PER_SEGMENT));
	end

	// Input register, segment split, and the saturation, value and segment delay lines.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			hm_s1 <= hm_c;
			sat_s[1] <= s_tdata[HUE_W+CB-1:HUE_W];
			bri_s[1] <= s_tdata[HUE_W+2*CB-1:HUE_W+CB];
		end
		if (en[2]) begin
			t_s2 <= t_c;
			seg_s[2] <= seg_c;
		end
		for (int k = 2; k <= SC; k++) begin
			if (en[k]) begin
				sat_s[k] <= sat_s[k-1];
				bri_s[k] <= bri_s[k-1];
			end
		end
		for (int k = 3; k <= SC; k++) begin
			if (en[k]) begin
				seg_s[k] <= seg_s[k-1];
			end
		end
	end

	// Falling ramp shared by all three channels.
	shsv_ramp u_ramp (
		.clk  (clk),
		.en   (en[shsv_pkg::STG_RAMP_LAST:shsv_pkg::STG_RAMP_FIRST]),
		.t    (t_s2),
		.fall (fall)
	);

	assign seg_g_c = seg_rotate(seg_s[SC], 3'(shsv_pkg::CH_OFF_GREEN));
	assign seg_b_c = seg_rotate(seg_s[SC], 3'(shsv_pkg::CH_OFF_BLUE));

	shsv_chan u_red (
		.clk   (clk),
		.en    (en[NSTG:shsv_pkg::STG_CHAN_FIRST]),
		.seg   (seg_s[SC]),
		.fall  (fall),
		.sat   (sat_s[SC]),
		.bri   (bri_s[SC]),
		.color (red)
	);

	shsv_chan u_green (
		.clk   (clk),
		.en    (en[NSTG:shsv_pkg::STG_CHAN_FIRST]),
		.seg   (seg_g_c),
		.fall  (fall),
		.sat   (sat_s[SC]),
		.bri   (bri_s[SC]),
		.color (green)
	);

	shsv_chan u_blue (
		.clk   (clk),
		.en    (en[NSTG:shsv_pkg::STG_CHAN_FIRST]),
		.seg   (seg_b_c),
		.fall  (fall),
		.sat   (sat_s[SC]),
		.bri   (bri_s[SC]),
		.color (blue)
	);

	assign m_tdata = {blue, green, red};

endmodule

FILE: rtl/core/shsv_ramp.sv
module shsv_ramp (
	input  logic clk,
	input  logic [shsv_pkg::STG_RAMP_LAST:shsv_pkg::STG_RAMP_FIRST] en,
	input  logic [shsv_pkg::T_W-1:0] t,
	output logic [shsv_pkg::W_W-1:0] fall
);

	localparam int unsigned T_W = shsv_pkg::T_W;
	localparam int unsigned PH_W = shsv_pkg::PH_W;
	localparam int unsigned PPR_W = shsv_pkg::PPR_W;
	localparam int unsigned X_W = shsv_pkg::X_W;
	localparam int unsigned W_W = shsv_pkg::W_W;
	localparam int unsigned ACC_W = shsv_pkg::ACC_W;
	localparam int unsigned Z_W = shsv_pkg::Z_W;
	localparam int unsigned MUL_W = shsv_pkg::MUL_W;
	localparam int unsigned SH_W = shsv_pkg::SH_W;
	localparam int unsigned HN = shsv_pkg::HORNER_N;
	localparam int unsigned STG_Z = shsv_pkg::STG_Z;
	localparam int unsigned STG_COS = shsv_pkg::STG_COS;
	localparam int unsigned STG_LAST = shsv_pkg::STG_RAMP_LAST;
	localparam int unsigned WS_W = ACC_W + 1;

	logic [PPR_W-1:0] prod_s3;
	logic [T_W-1:0]   t_s3;
	logic [PH_W-1:0]  qest_s4;
	logic [X_W-1:0]   qd_s4;
	logic [T_W-1:0]   t_s4;
	logic [PH_W-1:0]  p_s5;
	logic [Z_W-1:0]   z_d [STG_Z:STG_COS-2];
	logic             fold_d [STG_Z:STG_COS];
	logic [MUL_W-1:0] mul_h [0:HN-1];
	logic [ACC_W-1:0] acc_h [0:HN-1];
	logic [ACC_W-1:0] acc_src [0:HN-1];
	logic [W_W-1:0]   fall_s17;

	logic [X_W-1:0]   x_c;
	logic [X_W-1:0]   rem_c;
	logic [PH_W:0]    mirror_c;
	logic [PH_W-1:0]  q_c;
	logic [WS_W-1:0]  wsum_c;
	logic [W_W-1:0]   w_c;

	// Phase estimate, its remainder and the fold to a quarter turn.
	always_comb begin
		x_c = {t_s4, {shsv_pkg::PH_FRAC{1'b0}}};
		rem_c = x_c - qd_s4;
		mirror_c = (PH_W + 1)'(shsv_pkg::ONE_Q16) - {1'b0, p_s5};
		q_c = p_s5[PH_W-1] ? mirror_c[PH_W-1:0] : p_s5;
	end

	// Horner operand of each step: the seed first, then the previous step.
	always_comb begin
		acc_src[0] = ACC_W'(shsv_pkg::COS_SEED);
		for (int i = 1; i < HN; i++) begin
			acc_src[i] = acc_h[i-1];
		end
	end

	// Cosine to a Q16 weight, clamped at one.
	always_comb begin
		wsum_c = WS_W'(shsv_pkg::ONE_Q30) + WS_W'(acc_h[HN-1]) + WS_W'(shsv_pkg::ROUND_Q15);
		w_c = wsum_c[WS_W-1:15];
		if (w_c > W_W'(shsv_pkg::ONE_Q16)) begin
			w_c = W_W'(shsv_pkg::ONE_Q16);
		end
	end

	// Phase stages: reciprocal multiply, back-multiply and correction.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			prod_s3 <= PPR_W'(t) * PPR_W'(shsv_pkg::PH_RECIP);
			t_s3 <= t;
		end
		if (en[4]) begin
			qest_s4 <= prod_s3[shsv_pkg::PH_RSHIFT-1:shsv_pkg::PH_RSHIFT-PH_W];
			qd_s4 <= X_W'(prod_s3[shsv_pkg::PH_RSHIFT-1:shsv_pkg::PH_RSHIFT-PH_W])
				* X_W'(shsv_pkg::HUE_UNITS_PER_SEGMENT);
			t_s4 <= t_s3;
		end
		if (en[5]) begin
			p_s5 <= qest_s4 + PH_W'(rem_c >= X_W'(shsv_pkg::HUE_UNITS_PER_SEGMENT));
		end
	end

	// Square of the folded phase, which is the polynomial variable in Q30.
	always_ff @(posedge clk) begin
		if (en[STG_Z]) begin
			z_d[STG_Z] <= Z_W'(q_c) * Z_W'(q_c);
			fold_d[STG_Z] <= p_s5[PH_W-1];
		end
		for (int k = STG_Z + 1; k <= STG_COS - 2; k++) begin
			if (en[k]) begin
				z_d[k] <= z_d[k-1];
			end
		end
		for (int k = STG_Z + 1; k <= STG_COS; k++) begin
			if (en[k]) begin
				fold_d[k] <= fold_d[k-1];
			end
		end
	end

	// Horner steps: one stage multiplies, the next subtracts and clamps at zero.
	always_ff @(posedge clk) begin
		for (int i = 0; i < HN; i++) begin
			if (en[STG_Z + 1 + 2 * i]) begin
				mul_h[i] <= MUL_W'(acc_src[i]) * MUL_W'(z_d[STG_Z + 2 * i]);
			end
			if (en[STG_Z + 2 + 2 * i]) begin
				if (mul_h[i][MUL_W-1:shsv_pkg::Q_FRAC] > SH_W'(shsv_pkg::horner_coef(3'(i)))) begin
					acc_h[i] <= '0;
				end else begin
					acc_h[i] <= ACC_W'(SH_W'(shsv_pkg::horner_coef(3'(i)))
						- mul_h[i][MUL_W-1:shsv_pkg::Q_FRAC]);
				end
			end
		end
	end

	// Falling ramp weight.
	always_ff @(posedge clk) begin
		if (en[STG_LAST]) begin
			fall_s17 <= fold_d[STG_COS] ? W_W'(shsv_pkg::ONE_Q16) - w_c : w_c;
		end
	end

	assign fall = fall_s17;

endmodule

FILE: rtl/core/shsv_chan.sv
module shsv_chan (
	input  logic clk,
	input  logic [shsv_pkg::STG_LAST:shsv_pkg::STG_CHAN_FIRST] en,
	input  shsv_pkg::seg_t seg,
	input  logic [shsv_pkg::W_W-1:0] fall,
	input  logic [shsv_pkg::CHANNEL_BITS-1:0] sat,
	input  logic [shsv_pkg::CHANNEL_BITS-1:0] bri,
	output logic [shsv_pkg::CHANNEL_BITS-1:0] color
);

	localparam int unsigned CB = shsv_pkg::CHANNEL_BITS;
	localparam int unsigned W_W = shsv_pkg::W_W;
	localparam int unsigned DEN = shsv_pkg::CHAN_MAX * shsv_pkg::ONE_Q16;
	localparam int unsigned DEN_W = CB + shsv_pkg::PH_FRAC;
	localparam int unsigned SW_W = CB + W_W;
	localparam int unsigned N_W = CB + DEN_W;
	localparam int unsigned SUM_W = N_W + 1;
	localparam int unsigned A_W = SUM_W - shsv_pkg::PH_FRAC;
	localparam int unsigned DIV_SHIFT = 24;
	localparam int unsigned DIV_RECIP = (1 << DIV_SHIFT) / shsv_pkg::CHAN_MAX;
	localparam int unsigned DIV_RECIP_W = $clog2(DIV_RECIP + 1);
	localparam int unsigned PR_W = A_W + DIV_RECIP_W;
	localparam int unsigned QE_W = PR_W - DIV_SHIFT;
	localparam int unsigned QD_W = QE_W + CB;
	localparam int unsigned S0 = shsv_pkg::STG_CHAN_FIRST;

	logic [W_W-1:0]   invw_s18;
	logic [CB-1:0]    sat_s18;
	logic [CB-1:0]    bri_s18;
	logic [SW_W-1:0]  sw_s19;
	logic [CB-1:0]    bri_s19;
	logic [DEN_W-1:0] d_s20;
	logic [CB-1:0]    bri_s20;
	logic [N_W-1:0]   n_s21;
	logic [A_W-1:0]   a_s22;
	logic [PR_W-1:0]  pr_s23;
	logic [A_W-1:0]   a_s23;
	logic [QE_W-1:0]  qe_s24;
	logic [QD_W-1:0]  qd_s24;
	logic [A_W-1:0]   a_s24;
	logic [CB-1:0]    color_s25;

	logic [W_W-1:0]   invw_c;
	logic [SUM_W-1:0] sum_c;
	logic [QD_W-1:0]  rem_c;
	logic [QE_W-1:0]  q_c;

	// Complement of the channel weight, chosen by segment.
	always_comb begin
		case (seg)
			shsv_pkg::SEG_TOP_A, shsv_pkg::SEG_TOP_B: invw_c = '0;
			shsv_pkg::SEG_FALL: invw_c = W_W'(shsv_pkg::ONE_Q16) - fall;
			shsv_pkg::SEG_RISE: invw_c = fall;
			default: invw_c = W_W'(shsv_pkg::ONE_Q16);
		endcase
	end

	// Rounding offset, and the quotient correction of the divide by the channel maximum.
	always_comb begin
		sum_c = SUM_W'(n_s21) + SUM_W'(DEN / 2);
		rem_c = QD_W'(a_s24) - qd_s24;
		q_c = qe_s24 + QE_W'(rem_c >= QD_W'(shsv_pkg::CHAN_MAX));
	end

	// Channel arithmetic: chroma loss, scale by value, round, divide, saturate.
	always_ff @(posedge clk) begin
		if (en[S0]) begin
			invw_s18 <= invw_c;
			sat_s18 <= sat;
			bri_s18 <= bri;
		end
		if (en[S0 + 1]) begin
			sw_s19 <= SW_W'(sat_s18) * SW_W'(invw_s18);
			bri_s19 <= bri_s18;
		end
		if (en[S0 + 2]) begin
			d_s20 <= DEN_W'(DEN) - DEN_W'(sw_s19);
			bri_s20 <= bri_s19;
		end
		if (en[S0 + 3]) begin
			n_s21 <= N_W'(bri_s20) * N_W'(d_s20);
		end
		if (en[S0 + 4]) begin
			a_s22 <= sum_c[SUM_W-1:shsv_pkg::PH_FRAC];
		end
		if (en[S0 + 5]) begin
			pr_s23 <= PR_W'(a_s22) * PR_W'(DIV_RECIP);
			a_s23 <= a_s22;
		end
		if (en[S0 + 6]) begin
			qe_s24 <= pr_s23[PR_W-1:DIV_SHIFT];
			qd_s24 <= QD_W'(pr_s23[PR_W-1:DIV_SHIFT]) * QD_W'(shsv_pkg::CHAN_MAX);
			a_s24 <= a_s23;
		end
		if (en[S0 + 7]) begin
			if (q_c > QE_W'(shsv_pkg::CHAN_MAX)) begin
				color_s25 <= CB'(shsv_pkg::CHAN_MAX);
			end else begin
				color_s25 <= q_c[CB-1:0];
			end
		end
	end

	assign color = color_s25;

endmodule

FILE: bench/smooth_hsv_to_rgb_unit_checker.sv
`timescale 1ns / 1ps

module smooth_hsv_to_rgb_unit_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [shsv_pkg::S_TDATA_W-1:0] s_tdata, // hue[11:0], saturation[19:12], brightness[27:20], zero[31:28]
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [shsv_pkg::M_TDATA_W-1:0] m_tdata,  // red[7:0], green[15:8], blue[23:16]
	output int unsigned mismatch_count,
	output int unsigned pending_results
);

	// Taylor coefficients of cos((pi/2) r) in Q30, lowest order first.
	localparam longint unsigned COS_C2 = 64'd1324675879;
	localparam longint unsigned COS_C4 = 64'd272375560;
	localparam longint unsigned COS_C6 = 64'd22401990;
	localparam longint unsigned COS_C8 = 64'd987048;
	localparam longint unsigned COS_C10 = 64'd27061;
	localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
	localparam longint unsigned UNIT_Q16 = 64'd65536;
	localparam int unsigned PRINT_CAP = 50;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		logic [27:0] pixel;
		rgb_t rgb;
	} expected_color_t;

	expected_color_t expected_colors[$];

	// One Horner step: c - acc * z, truncated to Q30 and clamped at zero.
	function automatic longint unsigned horner_step(input longint unsigned c,
			input longint unsigned acc, input longint unsigned z);
		longint unsigned prod;
		prod = (acc * z) >> 30;
		return (c > prod) ? c - prod : 64'd0;
	endfunction

	// cos(pi * q / 65536) in Q30 for q up to a quarter turn.
	function automatic longint unsigned quarter_cos_q30(input longint unsigned q);
		longint unsigned r;
		longint unsigned z;
		longint unsigned acc;
		r = q << 15;
		z = (r * r) >> 30;
		acc = horner_step(COS_C8, COS_C10, z);
		acc = horner_step(COS_C6, acc, z);
		acc = horner_step(COS_C4, acc, z);
		acc = horner_step(COS_C2, acc, z);
		return horner_step(UNIT_Q30, acc, z);
	endfunction

	// Raised-cosine ramp in Q16, falling from one to zero across the segment.
	function automatic longint unsigned fall_ramp_q16(input longint unsigned p);
		longint unsigned q;
		longint unsigned w;
		q = (p < 64'd32768) ? p : UNIT_Q16 - p;
		w = (UNIT_Q30 + quarter_cos_q30(q) + 64'd16384) >> 15;
		if (w > UNIT_Q16)
			w = UNIT_Q16;
		return (p < 64'd32768) ? w : UNIT_Q16 - w;
	endfunction

	// Weight of one channel from its shifted hue.
	function automatic longint unsigned hue_weight_q16(input logic [11:0] hue,
			input int unsigned seg_shift);
		longint unsigned x;
		longint unsigned t;
		longint unsigned p;
		shsv_pkg::seg_t seg;
		x = (64'(hue) + 64'(seg_shift) * shsv_pkg::HUE_UNITS_PER_SEGMENT)
			% shsv_pkg::HUE_TURN;
		seg = shsv_pkg::seg_t'(x / shsv_pkg::HUE_UNITS_PER_SEGMENT);
		t = x % shsv_pkg::HUE_UNITS_PER_SEGMENT;
		p = (t << 16) / shsv_pkg::HUE_UNITS_PER_SEGMENT;
		case (seg)
			shsv_pkg::SEG_TOP_A, shsv_pkg::SEG_TOP_B: return UNIT_Q16;
			shsv_pkg::SEG_FALL: return fall_ramp_q16(p);
			shsv_pkg::SEG_RISE: return UNIT_Q16 - fall_ramp_q16(p);
			default: return 64'd0;
		endcase
	endfunction

	// v - c + c*W with rounding half up and saturation.
	function automatic logic [7:0] mix_channel(input longint unsigned sat,
			input longint unsigned bright, input longint unsigned w);
		longint unsigned den;
		longint unsigned num;
		longint unsigned o;
		den = 64'(shsv_pkg::CHAN_MAX) * UNIT_Q16;
		num = bright * (den - sat * (UNIT_Q16 - w));
		o = (num + den / 2) / den;
		if (o > shsv_pkg::CHAN_MAX)
			o = shsv_pkg::CHAN_MAX;
		return o[7:0];
	endfunction

	function automatic rgb_t predict_rgb(input logic [11:0] hue, input logic [7:0] sat,
			input logic [7:0] bright);
		rgb_t c;
		c.red = mix_channel(sat, bright, hue_weight_q16(hue, 0));
		c.green = mix_channel(sat, bright, hue_weight_q16(hue, shsv_pkg::CH_OFF_GREEN));
		c.blue = mix_channel(sat, bright, hue_weight_q16(hue, shsv_pkg::CH_OFF_BLUE));
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		pending_results = 0;
	end

	// Compare each output transfer with the oldest prediction, then queue new ones.
	always @(posedge clk) begin : watch
		expected_color_t want;
		rgb_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("unexpected output %h", m_tdata));
				end else begin
					want = expected_colors.pop_front();
					if (got.red !== want.rgb.red)
						report_mismatch($sformatf("pixel %h: red %h, expected %h",
							want.pixel, got.red, want.rgb.red));
					if (got.green !== want.rgb.green)
						report_mismatch($sformatf("pixel %h: green %h, expected %h",
							want.pixel, got.green, want.rgb.green));
					if (got.blue !== want.rgb.blue)
						report_mismatch($sformatf("pixel %h: blue %h, expected %h",
							want.pixel, got.blue, want.rgb.blue));
				end
			end
			if (s_tvalid && s_tready) begin
				want.pixel = s_tdata[27:0];
				want.rgb = predict_rgb(s_tdata[11:0], s_tdata[19:12], s_tdata[27:20]);
				expected_colors.push_back(want);
			end
			pending_results <= expected_colors.size();
		end
	end

endmodule

FILE: bench/smooth_hsv_to_rgb_unit_tb.sv
`timescale 1ns / 1ps

module smooth_hsv_to_rgb_unit_tb;

	localparam int unsigned PERIOD_NS = 20;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_OFF_CYCLES = 150;
	localparam int unsigned PHASE_ITEMS = 295;
	localparam longint unsigned LIMIT_NS = 64'd400_000 * PERIOD_NS;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [shsv_pkg::S_TDATA_W-1:0] s_tdata; // hue[11:0], saturation[19:12], brightness[27:20], zero[31:28]
	logic m_tvalid;
	logic m_tready;
	logic [shsv_pkg::M_TDATA_W-1:0] m_tdata;  // red[7:0], green[15:8], blue[23:16]

	int unsigned mismatch_count;
	int unsigned pending_results;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_cycles = 0;

	always #(PERIOD_NS / 2) clk = ~clk;

	smooth_hsv_to_rgb_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	smooth_hsv_to_rgb_unit_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatch_count(mismatch_count),
		.pending_results(pending_results)
	);

	// Offer one pixel after a random gap and hold it until its transfer.
	task automatic transfer_pixel(input logic [11:0] hue, input logic [7:0] sat,
			input logic [7:0] bright);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, bright, sat, hue};
		do @(posedge clk); while (!s_tready);
	endtask

	// Random pixels; extremes of saturation and brightness come up often.
	task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		logic [11:0] hue;
		logic [7:0] sat;
		logic [7:0] bright;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int unsigned i = 0; i < count; i++) begin
			hue = ($urandom_range(9) == 0) ? 12'($urandom_range(4095, 2880))
				: 12'($urandom_range(2879));
			case ($urandom_range(7))
				0: sat = 8'd0;
				1: sat = 8'd255;
				default: sat = 8'($urandom_range(255));
			endcase
			case ($urandom_range(7))
				0: bright = 8'd0;
				1: bright = 8'd255;
				default: bright = 8'($urandom_range(255));
			endcase
			transfer_pixel(hue, sat, bright);
		end
	endtask

	// Output side: random stalls, or a long hold-off when one is requested.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Segment borders, hues past one turn, and the zero and full extremes.
		transfer_pixel(12'd0, 8'd255, 8'd255);
		transfer_pixel(12'd479, 8'd255, 8'd255);
		transfer_pixel(12'd480, 8'd255, 8'd255);
		transfer_pixel(12'd481, 8'd255, 8'd255);
		transfer_pixel(12'd720, 8'd255, 8'd255);
		transfer_pixel(12'd959, 8'd255, 8'd255);
		transfer_pixel(12'd960, 8'd255, 8'd255);
		transfer_pixel(12'd1440, 8'd255, 8'd255);
		transfer_pixel(12'd1919, 8'd255, 8'd255);
		transfer_pixel(12'd1920, 8'd255, 8'd255);
		transfer_pixel(12'd2160, 8'd255, 8'd255);
		transfer_pixel(12'd2399, 8'd255, 8'd255);
		transfer_pixel(12'd2400, 8'd255, 8'd255);
		transfer_pixel(12'd2879, 8'd255, 8'd255);
		transfer_pixel(12'd2880, 8'd255, 8'd255);
		transfer_pixel(12'd3360, 8'd200, 8'd180);
		transfer_pixel(12'd4095, 8'd255, 8'd255);
		transfer_pixel(12'd1000, 8'd0, 8'd200);
		transfer_pixel(12'd4095, 8'd0, 8'd255);
		transfer_pixel(12'd600, 8'd255, 8'd0);
		transfer_pixel(12'd0, 8'd0, 8'd0);
		transfer_pixel(12'd300, 8'd1, 8'd1);
		transfer_pixel(12'd2000, 8'd128, 8'd77);
		transfer_pixel(12'd1234, 8'd170, 8'd85);

		// The output side holds off while pixels keep coming, so the pipe fills.
		hold_cycles = HOLD_OFF_CYCLES;
		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 73, 0);
		run_phase(PHASE_ITEMS, 0, 73);
		run_phase(PHASE_ITEMS, 16, 16);
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;

		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("smooth_hsv_to_rgb_unit test passed");
		else
			$display("smooth_hsv_to_rgb_unit test failed");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("smooth_hsv_to_rgb_unit test failed");
		$finish;
	end

endmodule
